### design/sccmp_pkg.sv
package sccmp_pkg;

   // item opcodes
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } opcode_type;

   localparam int ADDR_W = 17;
   localparam int WORD_W = 32;
   localparam int COUNT_W = 64;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [COUNT_W-1:0] count_type;

   // one accepted item as it sits in the input register
   typedef struct packed {
      logic [1:0] opcode;
      addr_type   address;
      word_type   write_data;
   } item_type;

   // register offsets
   localparam addr_type OFS_STATUS = 17'h00004;
   localparam addr_type OFS_CNT_LO = 17'h00008;
   localparam addr_type OFS_CNT_HI = 17'h0000c;
   localparam addr_type OFS_FREQ0  = 17'h00020;
   localparam addr_type OFS_FREQ1  = 17'h00024;
   localparam addr_type OFS_CMP_LO = 17'h10020;
   localparam addr_type OFS_CMP_HI = 17'h10024;
   localparam addr_type OFS_CTRL   = 17'h1002c;

   // read constants and control bits
   localparam word_type DEFAULT_RATE_HZ = 32'd24000000;
   localparam word_type STATUS_CONST    = 32'h00000100;
   localparam word_type FREQ1_CONST     = 32'h00000200;
   localparam int CTRL_EN_BIT   = 0;
   localparam int CTRL_MASK_BIT = 1;

endpackage

### design/system_counter_compare_timer.sv
// an accepted item sits in the input register, then its result is captured
// in the result register; a stalled result holds the item in the input register
// throughput: one item per cycle while rsp_ready is high; the counter increment
// and 64-bit compare sit between the input register and the result register
// reset: synchronous, active high; counter, compare value and control clear to zero,
// frequency register returns to 24000000
module system_counter_compare_timer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [16:0] req_address,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_level,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   sccmp_pkg::word_type tick_rate_ff;
   sccmp_pkg::item_type item;
   logic                item_valid;
   logic                item_ready;

   // reported frequency register
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= sccmp_pkg::DEFAULT_RATE_HZ;
      end else if (csr_write_enable) begin
         tick_rate_ff <= csr_write_data;
      end
   end

   sccmp_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .item_valid     (item_valid),
      .item_ready     (item_ready),
      .item           (item)
   );

   sccmp_exec u_exec (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item          (item),
      .tick_rate     (tick_rate_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_data (rsp_read_data),
      .rsp_irq_level (rsp_irq_level)
   );

endmodule

### design/sccmp_in_stage.sv
module sccmp_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [16:0]        req_address,
   input  logic [31:0]        req_write_data,
   output logic               item_valid,
   input  logic               item_ready,
   output sccmp_pkg::item_type item
);

   logic                valid_ff;
   logic                valid_in;
   sccmp_pkg::item_type item_ff;
   logic                take;
   logic                load;

   // input register empties when the execute stage takes the item
   assign take      = valid_ff && item_ready;
   assign req_ready = !valid_ff || item_ready;
   assign load      = req_valid && req_ready;
   assign valid_in  = load || (valid_ff && !take);

   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.opcode     <= req_opcode;
         item_ff.address    <= req_address;
         item_ff.write_data <= req_write_data;
      end
   end

endmodule

### design/sccmp_exec.sv
module sccmp_exec (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   output logic                item_ready,
   input  sccmp_pkg::item_type item,
   input  logic [31:0]         tick_rate,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_read_data,
   output logic                rsp_irq_level
);

   sccmp_pkg::count_type count_ff, count_in;
   sccmp_pkg::count_type compare_ff, compare_in;
   sccmp_pkg::word_type  control_ff, control_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sccmp_pkg::word_type  read_data_ff, read_data_in;
   logic                 irq_ff, irq_in;
   logic                 fire;
   logic                 is_read;
   logic                 is_write;

   // result register frees up when the consumer takes the item
   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign fire       = item_valid && item_ready;

   // opcode decode, unused code does nothing
   always_comb begin
      is_read  = 1'b0;
      is_write = 1'b0;
      count_in = count_ff;
      case (sccmp_pkg::opcode_type'(item.opcode))
         sccmp_pkg::OP_TICK:  count_in = count_ff + 64'd1;
         sccmp_pkg::OP_READ:  is_read  = 1'b1;
         sccmp_pkg::OP_WRITE: is_write = 1'b1;
         default:             count_in = count_ff;
      endcase
   end

   // register writes
   always_comb begin
      compare_in = compare_ff;
      control_in = control_ff;
      if (is_write) begin
         case (item.address)
            sccmp_pkg::OFS_CMP_LO: compare_in[31:0]  = item.write_data;
            sccmp_pkg::OFS_CMP_HI: compare_in[63:32] = item.write_data;
            sccmp_pkg::OFS_CTRL:   control_in        = item.write_data;
            default:               control_in        = control_ff;
         endcase
      end
   end

   // register reads
   always_comb begin
      read_data_in = '0;
      if (is_read) begin
         case (item.address)
            sccmp_pkg::OFS_STATUS: read_data_in = sccmp_pkg::STATUS_CONST;
            sccmp_pkg::OFS_FREQ0:
               read_data_in = (tick_rate != '0) ? tick_rate : sccmp_pkg::DEFAULT_RATE_HZ;
            sccmp_pkg::OFS_FREQ1:  read_data_in = sccmp_pkg::FREQ1_CONST;
            sccmp_pkg::OFS_CNT_LO: read_data_in = count_ff[31:0];
            sccmp_pkg::OFS_CNT_HI: read_data_in = count_ff[63:32];
            sccmp_pkg::OFS_CMP_LO: read_data_in = compare_ff[31:0];
            sccmp_pkg::OFS_CMP_HI: read_data_in = compare_ff[63:32];
            sccmp_pkg::OFS_CTRL:   read_data_in = control_ff;
            default:               read_data_in = '0;
         endcase
      end
   end

   // interrupt level from the state after this item
   assign irq_in = control_in[sccmp_pkg::CTRL_EN_BIT] &&
                   !control_in[sccmp_pkg::CTRL_MASK_BIT] &&
                   (compare_in <= count_in);

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);

   // state and result control
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         compare_ff   <= '0;
         control_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff   <= count_in;
            compare_ff <= compare_in;
            control_ff <= control_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         read_data_ff <= read_data_in;
         irq_ff       <= irq_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = read_data_ff;
   assign rsp_irq_level = irq_ff;

endmodule
